// ===== rtl/gmd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gradient magnitude/direction block.
// No dependencies.
package gmd_pkg;

    localparam int PIX_W   = 14;   // smoothed pixel
    localparam int GRAD_W  = 15;   // signed difference
    localparam int MAG_W   = 15;   // magnitude
    localparam int DIR_W   = 2;    // direction code
    localparam int COORD_W = 10;   // emitted column / row
    localparam int SIZE_W  = 11;   // frame_width / frame_height registers
    localparam int THR_W   = 15;   // magnitude_threshold register
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Line store word: {older row, previous row}
    localparam int WORD_W = 2 * PIX_W;

    // floor(a/3) == (a * RECIP3) >> RECIP3_SH for every a < 2**15
    localparam int RECIP3_W  = 15;
    localparam logic [RECIP3_W-1:0] RECIP3 = 15'd21846;
    localparam int RECIP3_SH = 16;
    localparam int THIRD_W   = PIX_W - 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_THRESH   = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam logic [THR_W-1:0]  MAG_THRESH_RST   = 15'd192;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_WEAK  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_HORIZ = 2'd1;
    localparam logic [DIR_W-1:0] DIR_VERT  = 2'd2;

    // One result to compute: position, four neighbours, end-of-beat mark
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   right;
        logic [PIX_W-1:0]   up;
        logic [PIX_W-1:0]   down;
        logic               last;
    } t_desc;

    localparam int OUT_DATA_BITS = 2 * COORD_W + 2 * GRAD_W + MAG_W + DIR_W;
    localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W     = ((PIX_W + 7) / 8) * 8;

endpackage

// ===== rtl/gmd_line_mem.sv =====
`timescale 1ns / 1ps
// Line store: one write port, two registered read ports, write-to-read bypass.
// No package dependency.
module gmd_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 28,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q_a;
    logic [DW-1:0] r_q_b;
    logic [DW-1:0] r_byp;
    logic          r_byp_a;
    logic          r_byp_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // same-edge write and read of one entry: hand over the new word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q_a   <= r_mem[i_raddr_a];
            r_q_b   <= r_mem[i_raddr_b];
            r_byp   <= i_wdata;
            r_byp_a <= i_we && (i_waddr == i_raddr_a);
            r_byp_b <= i_we && (i_waddr == i_raddr_b);
        end
    end

    assign o_rdata_a = r_byp_a ? r_byp : r_q_a;
    assign o_rdata_b = r_byp_b ? r_byp : r_q_b;

endmodule

// ===== rtl/gmd_grad_calc.sv =====
`timescale 1ns / 1ps
// Gradient arithmetic pipeline: differences, magnitude, direction, output register.
// Depends on gmd_pkg.
module gmd_grad_calc
    import gmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_desc_valid,
    output logic                  o_desc_ready,
    input  t_desc                 i_desc,
    input  logic [THR_W-1:0]      i_threshold,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data,
    output logic                  o_last
);

    // stage 1: differences
    logic                     r_v1;
    logic [COORD_W-1:0]       r1_col, r1_row;
    logic                     r1_last;
    logic signed [GRAD_W-1:0] r1_gx, r1_gy;
    // stage 2: absolute values and dominance
    logic                     r_v2;
    logic [COORD_W-1:0]       r2_col, r2_row;
    logic                     r2_last;
    logic signed [GRAD_W-1:0] r2_gx, r2_gy;
    logic [MAG_W-1:0]         r2_sum;
    logic [PIX_W-1:0]         r2_big;
    logic                     r2_add, r2_xdom;
    // stage 3: third of the larger value
    logic                     r_v3;
    logic [COORD_W-1:0]       r3_col, r3_row;
    logic                     r3_last;
    logic signed [GRAD_W-1:0] r3_gx, r3_gy;
    logic [MAG_W-1:0]         r3_sum;
    logic [THIRD_W-1:0]       r3_third;
    logic                     r3_add, r3_xdom;
    // output register
    logic                     r_ov;
    logic [COORD_W-1:0]       r4_col, r4_row;
    logic                     r4_last;
    logic signed [GRAD_W-1:0] r4_gx, r4_gy;
    logic [MAG_W-1:0]         r4_mag;
    logic [DIR_W-1:0]         r4_dir;

    logic en1, en2, en3, en4;
    logic [PIX_W-1:0] ax, ay;
    logic x_big, y_big;
    logic [PIX_W+RECIP3_W-1:0] prod;
    logic [MAG_W-1:0] mag;

    assign en4 = !r_ov || i_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_desc_ready = en1;

    always_comb begin
        ax    = r1_gx[GRAD_W-1] ? PIX_W'(-r1_gx) : PIX_W'(r1_gx);
        ay    = r1_gy[GRAD_W-1] ? PIX_W'(-r1_gy) : PIX_W'(r1_gy);
        x_big = MAG_W'(ax) > {ay, 1'b0};
        y_big = MAG_W'(ay) > {ax, 1'b0};
    end

    assign prod = r2_big * RECIP3;
    assign mag  = r3_sum + (r3_add ? MAG_W'(r3_third) : MAG_W'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_desc_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_col  <= i_desc.col;
            r1_row  <= i_desc.row;
            r1_last <= i_desc.last;
            r1_gx   <= GRAD_W'(i_desc.right) - GRAD_W'(i_desc.left);
            r1_gy   <= GRAD_W'(i_desc.down) - GRAD_W'(i_desc.up);
        end
        if (en2) begin
            r2_col  <= r1_col;
            r2_row  <= r1_row;
            r2_last <= r1_last;
            r2_gx   <= r1_gx;
            r2_gy   <= r1_gy;
            r2_sum  <= MAG_W'(ax) + MAG_W'(ay);
            r2_big  <= x_big ? ax : ay;
            r2_add  <= x_big || y_big;
            r2_xdom <= ax > ay;
        end
        if (en3) begin
            r3_col   <= r2_col;
            r3_row   <= r2_row;
            r3_last  <= r2_last;
            r3_gx    <= r2_gx;
            r3_gy    <= r2_gy;
            r3_sum   <= r2_sum;
            r3_third <= prod[RECIP3_SH +: THIRD_W];
            r3_add   <= r2_add;
            r3_xdom  <= r2_xdom;
        end
        if (en4) begin
            r4_col  <= r3_col;
            r4_row  <= r3_row;
            r4_last <= r3_last;
            r4_gx   <= r3_gx;
            r4_gy   <= r3_gy;
            r4_mag  <= mag;
            if (mag < i_threshold) begin
                r4_dir <= DIR_WEAK;
            end else if (r3_xdom) begin
                r4_dir <= DIR_HORIZ;
            end else begin
                r4_dir <= DIR_VERT;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_last  = r4_last;
    assign o_data  = {(OUT_DATA_W - OUT_DATA_BITS)'(0),
                      r4_dir, r4_mag, r4_gy, r4_gx, r4_row, r4_col};

endmodule

// ===== rtl/gradient_magnitude_direction.sv =====
`timescale 1ns / 1ps
// Top level: frame position counters, line store access, result sequencing.
// Depends on gmd_pkg, gmd_line_mem, gmd_grad_calc.
//
// s_axis: one smoothed pixel per beat in raster order; tdata[13:0] = pixel.
// m_axis: gradient results; tlast marks the final result a pixel releases.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write frame_width (0), frame_height (1),
// magnitude_threshold (2); write only while no pixel is in flight.
// Pixel (x, r) releases the result of (x, r-1); row 0 releases nothing.
// Bottom-row pixels also release the bottom-row pixel to their left, and the
// last pixel of the frame releases itself.
// Results pass the sequencing stage, then the gmd_grad_calc pipeline, to m_axis.
// Throughput unless m_axis stalls: one pixel per cycle in rows 0..height-2;
// a bottom-row pixel holds the sequencing stage for its results, one per cycle.
// Line store: one {older row, previous row} word per column, read at x and x+1
// on accept, written back as the pixel leaves; a write-to-read bypass covers
// the two-pixel-wide frame.
// Reset (synchronous, active low): counters to frame origin, pipeline emptied,
// registers to 640 / 480 / 192; line store not cleared.
// Stalls: the pipeline holds and fills its bubbles while m_axis_tready is low;
// s_axis_tready drops once the sequencing stage cannot drain.
module gradient_magnitude_direction
    import gmd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel stream; tdata: [13:0] pixel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result stream; tdata: [9:0] column, [19:10] row, [34:20] grad_x,
    // [49:35] grad_y, [64:50] magnitude, [66:65] direction
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,   // last_result
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int HW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW  = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
    localparam int YW  = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ? $clog2(MAX_HEIGHT + 1) : SIZE_W;

    // pending-result bits of the sequencing stage
    localparam int P_MAIN = 0;   // pixel above
    localparam int P_LEFT = 1;   // bottom-row pixel to the left
    localparam int P_SELF = 2;   // last pixel of the frame

    // configuration
    logic [SIZE_W-1:0] r_cfg_width, r_cfg_height;
    logic [THR_W-1:0]  r_cfg_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= FRAME_WIDTH_RST;
            r_cfg_height <= FRAME_HEIGHT_RST;
            r_cfg_thresh <= MAG_THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[SIZE_W-1:0];
                CFG_MAG_THRESH:   r_cfg_thresh <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size, clamped to 2..MAX
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;

    always_comb begin
        priority if (XW'(r_cfg_width) < XW'(2)) w_eff = XW'(2);
        else if (XW'(r_cfg_width) > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
        else w_eff = XW'(r_cfg_width);
        priority if (YW'(r_cfg_height) < YW'(2)) h_eff = YW'(2);
        else if (YW'(r_cfg_height) > YW'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);
        else h_eff = YW'(r_cfg_height);
    end

    // position counters and recent bottom-row pixels
    logic [AW-1:0]    r_col;
    logic [HW-1:0]    r_row;
    logic [PIX_W-1:0] r_rec0, r_rec1;

    logic          accept;
    logic          pre_wrap;
    logic [XW-1:0] xc, nx;
    logic [YW-1:0] rc0, rc, nr;
    logic          col_wrap;
    logic [2:0]    new_pend;
    logic [PIX_W-1:0] in_pix;

    assign in_pix = s_axis_tdata[PIX_W-1:0];

    always_comb begin
        pre_wrap = XW'(r_col) >= w_eff;
        xc       = pre_wrap ? XW'(0) : XW'(r_col);
        rc0      = YW'(r_row) + (pre_wrap ? YW'(1) : YW'(0));
        rc       = (rc0 >= h_eff) ? YW'(0) : rc0;
        nx       = xc + XW'(1);
        nr       = rc + YW'(1);
        col_wrap = nx >= w_eff;
        new_pend[P_MAIN] = rc != YW'(0);
        new_pend[P_LEFT] = (rc == h_eff - YW'(1)) && (xc != XW'(0));
        new_pend[P_SELF] = (rc == h_eff - YW'(1)) && col_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rec0 <= '0;
            r_rec1 <= '0;
        end else if (accept) begin
            r_rec1 <= r_rec0;
            r_rec0 <= in_pix;
            if (col_wrap) begin
                r_col <= '0;
                r_row <= (nr >= h_eff) ? '0 : HW'(nr);
            end else begin
                r_col <= AW'(nx);
                r_row <= HW'(rc);
            end
        end
    end

    // line store
    logic [WORD_W-1:0] rd_a, rd_b;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    gmd_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (WORD_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_re      (accept),
        .i_raddr_a (AW'(xc)),
        .i_raddr_b (AW'(nx)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata)
    );

    // sequencing stage: one accepted pixel, its line-store words, and the
    // results it still owes
    logic             r_s1_valid;
    logic [2:0]       r_s1_pend;
    logic [AW-1:0]    r_s1_x;
    logic [HW-1:0]    r_s1_y;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] r_s1_rec0, r_s1_rec1;
    logic [PIX_W-1:0] r_s1_pl;      // previous row, column x-1
    logic             r_s1_first;   // column 0
    logic             r_s1_lastcol; // last column
    logic             r_s1_y2;      // row 2 or below
    logic             r_s1_x2;      // column 2 or beyond

    logic [PIX_W-1:0] c_mid, c_up, c_right;
    logic [2:0]       n_pend;
    logic             desc_valid, desc_ready, take, s1_leave;
    t_desc            desc;

    assign c_mid   = rd_a[PIX_W-1:0];
    assign c_up    = rd_a[WORD_W-1:PIX_W];
    assign c_right = rd_b[PIX_W-1:0];

    assign n_pend     = r_s1_pend & (r_s1_pend - 3'd1);
    assign desc_valid = r_s1_valid && (r_s1_pend != 3'd0);
    assign take       = desc_valid && desc_ready;
    assign s1_leave   = r_s1_valid && ((r_s1_pend == 3'd0) || (take && n_pend == 3'd0));
    assign s_axis_tready = !r_s1_valid || s1_leave;
    assign accept     = s_axis_tvalid && s_axis_tready;

    // write back {old previous, new pixel} as the pixel leaves
    assign mem_we    = s1_leave;
    assign mem_waddr = r_s1_x;
    assign mem_wdata = {c_mid, r_s1_pix};

    always_comb begin
        desc      = '0;
        desc.last = n_pend == 3'd0;
        priority if (r_s1_pend[P_MAIN]) begin
            desc.col   = COORD_W'(r_s1_x);
            desc.row   = COORD_W'(r_s1_y - 1'b1);
            desc.left  = r_s1_first   ? c_mid : r_s1_pl;
            desc.right = r_s1_lastcol ? c_mid : c_right;
            desc.up    = r_s1_y2      ? c_up  : c_mid;
            desc.down  = r_s1_pix;
        end else if (r_s1_pend[P_LEFT]) begin
            desc.col   = COORD_W'(r_s1_x - 1'b1);
            desc.row   = COORD_W'(r_s1_y);
            desc.left  = r_s1_x2 ? r_s1_rec1 : r_s1_rec0;
            desc.right = r_s1_pix;
            desc.up    = r_s1_pl;
            desc.down  = r_s1_rec0;
        end else begin
            desc.col   = COORD_W'(r_s1_x);
            desc.row   = COORD_W'(r_s1_y);
            desc.left  = r_s1_rec0;
            desc.right = r_s1_pix;
            desc.up    = c_mid;
            desc.down  = r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_pend  <= '0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_s1_pend  <= new_pend;
        end else if (s1_leave) begin
            r_s1_valid <= 1'b0;
            r_s1_pend  <= '0;
        end else if (take) begin
            r_s1_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x       <= AW'(xc);
            r_s1_y       <= HW'(rc);
            r_s1_pix     <= in_pix;
            r_s1_rec0    <= r_rec0;
            r_s1_rec1    <= r_rec1;
            r_s1_pl      <= c_mid;   // column x-1 word of the pixel before
            r_s1_first   <= xc == XW'(0);
            r_s1_lastcol <= col_wrap;
            r_s1_y2      <= rc >= YW'(2);
            r_s1_x2      <= xc >= XW'(2);
        end
    end

    gmd_grad_calc u_grad_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .o_desc_ready (desc_ready),
        .i_desc       (desc),
        .i_threshold  (r_cfg_thresh),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule
